### hdl/rbfa_pkg.sv
// ----------------------------------------------------------------------------
// rbfa_pkg
// Shared types and codes of the ranged best-fit buffer allocator.
// ----------------------------------------------------------------------------
package rbfa_pkg;

	localparam logic [1:0] REQ_ALLOC   = 2'd0;
	localparam logic [1:0] REQ_RELEASE = 2'd1;
	localparam logic [1:0] REQ_PRELOAD = 2'd2;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_FULL    = 2'd1;
	localparam logic [1:0] ST_BAD_REL = 2'd2;

	localparam int RANGE_W = 11;
	localparam logic [RANGE_W-1:0] RANGE_RESET = 11'd16;

	typedef struct packed {
		logic start_div;
		logic start_scan;
		logic commit;
	} rbfa_cmd_t;

	typedef struct packed {
		logic div_done;
		logic scan_done;
	} rbfa_stat_t;

endpackage

### hdl/rbfa_div.sv
// ----------------------------------------------------------------------------
// rbfa_div
// Restoring divider, one quotient bit per cycle, for the lower size bound.
// ----------------------------------------------------------------------------
module rbfa_div import rbfa_pkg::*; #(
	parameter int SIZE_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [SIZE_BITS-1:0] dividend,
	input  logic [RANGE_W-1:0]   divisor,
	output logic                 done,
	output logic [SIZE_BITS-1:0] quotient
);
	localparam int CW = $clog2(SIZE_BITS + 1);

	logic [SIZE_BITS-1:0] quo_q;
	logic [RANGE_W-1:0]   rem_q;
	logic [RANGE_W-1:0]   dsr_q;
	logic [CW-1:0]        cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [RANGE_W:0]     trial;

	assign trial = {rem_q, quo_q[SIZE_BITS-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && busy_q && cnt_q == CW'(1);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(SIZE_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			if (trial >= {1'b0, dsr_q}) begin
				rem_q <= RANGE_W'(trial - {1'b0, dsr_q});
				quo_q <= {quo_q[SIZE_BITS-2:0], 1'b1};
			end else begin
				rem_q <= trial[RANGE_W-1:0];
				quo_q <= {quo_q[SIZE_BITS-2:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule

### hdl/rbfa_datapath.sv
// ----------------------------------------------------------------------------
// rbfa_datapath
// Entry table, request registers and the two-window best-fit scan.
// ----------------------------------------------------------------------------
module rbfa_datapath import rbfa_pkg::*; #(
	parameter int MAX_ENTRIES = 64,
	parameter int SIZE_BITS   = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  logic [1:0]           req_type,
	input  logic [SIZE_BITS-1:0] req_size,
	input  logic [7:0]           device,
	input  logic [3:0]           data_type,
	input  logic [7:0]           node_color,
	input  logic [5:0]           entry_id,
	input  logic [RANGE_W-1:0]   match_range,
	input  rbfa_cmd_t            cmd,
	output rbfa_stat_t           stat,
	output logic [5:0]           granted_id,
	output logic                 is_new,
	output logic [1:0]           status
);
	localparam int IW = $clog2(MAX_ENTRIES);
	localparam int NW = $clog2(MAX_ENTRIES + 1);
	localparam int HW = SIZE_BITS + RANGE_W;

	logic [MAX_ENTRIES-1:0] valid_q, free_q, fixed_q, wild_q;
	logic [SIZE_BITS-1:0]   size_mem [MAX_ENTRIES];
	logic [7:0]             dev_mem  [MAX_ENTRIES];
	logic [3:0]             dt_mem   [MAX_ENTRIES];
	logic [7:0]             col_mem  [MAX_ENTRIES];
	logic [31:0]            age_mem  [MAX_ENTRIES];
	logic [NW-1:0]          count_q;
	logic [31:0]            age_ctr_q;

	logic [1:0]           type_q;
	logic [SIZE_BITS-1:0] size_q;
	logic [7:0]           dev_q, col_q;
	logic [3:0]           dt_q;
	logic [5:0]           id_q;
	logic [HW-1:0]        hi_q;
	logic                 div_start_q;
	logic [SIZE_BITS-1:0] lo;
	logic                 div_done;

	logic [NW-1:0]        idx_q;
	logic                 scanning_q, scan_done_q;
	logic                 rd_ok_s1;
	logic [IW-1:0]        rd_idx_s1;
	logic [SIZE_BITS-1:0] rd_size_s1;
	logic [31:0]          rd_age_s1;
	logic                 rd_use_s1, rd_fixed_s1;

	logic                 a_hit_q, b_hit_q;
	logic [IW-1:0]        a_idx_q, b_idx_q;
	logic [SIZE_BITS-1:0] a_size_q, b_size_q;
	logic [31:0]          a_age_q, b_age_q;

	logic a_in, b_in, a_better, b_better;
	logic rel_bad, full;
	logic [IW-1:0] id_ix, cnt_ix;

	rbfa_div #(.SIZE_BITS(SIZE_BITS)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start_q),
		.dividend(size_q), .divisor(match_range),
		.done(div_done), .quotient(lo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_start_q <= 1'b0;
		end else begin
			div_start_q <= cmd.start_div;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			type_q <= req_type;
			size_q <= req_size;
			dev_q  <= device;
			dt_q   <= data_type;
			col_q  <= node_color;
			id_q   <= entry_id;
		end
		if (cmd.start_div) begin
			hi_q <= HW'(size_q) * HW'(match_range);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scanning_q  <= 1'b0;
			scan_done_q <= 1'b0;
			idx_q       <= '0;
			rd_ok_s1    <= 1'b0;
		end else begin
			scan_done_q <= scanning_q && !cmd.start_scan && idx_q >= count_q;
			rd_ok_s1    <= scanning_q && !cmd.start_scan && idx_q < count_q;
			if (cmd.start_scan) begin
				scanning_q <= 1'b1;
				idx_q      <= '0;
			end else if (scanning_q) begin
				if (idx_q >= count_q) begin
					scanning_q <= 1'b0;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1   <= idx_q[IW-1:0];
		rd_size_s1  <= size_mem[idx_q[IW-1:0]];
		rd_age_s1   <= age_mem[idx_q[IW-1:0]];
		rd_fixed_s1 <= fixed_q[idx_q[IW-1:0]];
		rd_use_s1   <= valid_q[idx_q[IW-1:0]] && free_q[idx_q[IW-1:0]]
			&& dev_mem[idx_q[IW-1:0]] == dev_q && dt_mem[idx_q[IW-1:0]] == dt_q
			&& (wild_q[idx_q[IW-1:0]] || col_mem[idx_q[IW-1:0]] == col_q);
	end

	assign a_in = rd_use_s1 && rd_size_s1 >= size_q && HW'(rd_size_s1) <= hi_q;
	assign b_in = rd_use_s1 && !rd_fixed_s1 && rd_size_s1 < size_q && rd_size_s1 >= lo;
	assign a_better = !a_hit_q || rd_size_s1 < a_size_q
		|| (rd_size_s1 == a_size_q && rd_age_s1 < a_age_q);
	assign b_better = !b_hit_q || rd_size_s1 > b_size_q
		|| (rd_size_s1 == b_size_q && rd_age_s1 > b_age_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_hit_q <= 1'b0;
			b_hit_q <= 1'b0;
		end else if (cmd.start_scan) begin
			a_hit_q <= 1'b0;
			b_hit_q <= 1'b0;
		end else if (rd_ok_s1) begin
			if (a_in && a_better) a_hit_q <= 1'b1;
			if (b_in && b_better) b_hit_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_ok_s1 && a_in && a_better) begin
			a_idx_q <= rd_idx_s1; a_size_q <= rd_size_s1; a_age_q <= rd_age_s1;
		end
		if (rd_ok_s1 && b_in && b_better) begin
			b_idx_q <= rd_idx_s1; b_size_q <= rd_size_s1; b_age_q <= rd_age_s1;
		end
	end

	assign stat.div_done  = div_done;
	assign stat.scan_done = scan_done_q;

	assign id_ix   = IW'(id_q);
	assign cnt_ix  = count_q[IW-1:0];
	assign rel_bad = NW'(id_q) >= count_q || {26'd0, id_q} >= 32'(MAX_ENTRIES)
		|| !valid_q[id_ix];
	assign full    = count_q >= NW'(MAX_ENTRIES);

	logic reuse;
	assign reuse = type_q == REQ_ALLOC && match_range != '0 && (a_hit_q || b_hit_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			free_q    <= '0;
			fixed_q   <= '0;
			wild_q    <= '0;
			count_q   <= '0;
			age_ctr_q <= '0;
		end else if (cmd.commit) begin
			if (type_q == REQ_RELEASE) begin
				if (!rel_bad) begin
					free_q[id_ix] <= 1'b1;
					wild_q[id_ix] <= 1'b0;
					age_ctr_q     <= age_ctr_q + 1'b1;
				end
			end else if (type_q == REQ_ALLOC || type_q == REQ_PRELOAD) begin
				if (reuse) begin
					free_q[a_hit_q ? a_idx_q : b_idx_q] <= 1'b0;
				end else if (!full) begin
					valid_q[cnt_ix] <= 1'b1;
					free_q[cnt_ix]  <= type_q == REQ_PRELOAD;
					fixed_q[cnt_ix] <= type_q == REQ_PRELOAD;
					wild_q[cnt_ix]  <= type_q == REQ_PRELOAD;
					count_q         <= count_q + 1'b1;
					if (type_q == REQ_PRELOAD) age_ctr_q <= age_ctr_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			if (type_q == REQ_RELEASE) begin
				if (!rel_bad) begin
					col_mem[id_ix] <= col_q;
					age_mem[id_ix] <= age_ctr_q;
				end
			end else if (type_q == REQ_ALLOC || type_q == REQ_PRELOAD) begin
				if (reuse) begin
					if (!a_hit_q) size_mem[b_idx_q] <= size_q;
				end else if (!full) begin
					size_mem[cnt_ix] <= size_q;
					dev_mem[cnt_ix]  <= dev_q;
					dt_mem[cnt_ix]   <= dt_q;
					col_mem[cnt_ix]  <= '0;
					age_mem[cnt_ix]  <= (type_q == REQ_PRELOAD) ? age_ctr_q : '0;
				end
			end
		end
	end

	always_comb begin
		granted_id = '0;
		is_new     = 1'b0;
		status     = ST_OK;
		case (type_q)
			REQ_RELEASE: begin
				granted_id = id_q;
				if (rel_bad) status = ST_BAD_REL;
			end
			REQ_ALLOC, REQ_PRELOAD: begin
				if (reuse) begin
					granted_id = 6'(a_hit_q ? a_idx_q : b_idx_q);
				end else if (full) begin
					status = ST_FULL;
				end else begin
					granted_id = 6'(count_q);
					is_new     = 1'b1;
				end
			end
			default: ;
		endcase
	end
endmodule

### hdl/rbfa_ctrl.sv
// ----------------------------------------------------------------------------
// rbfa_ctrl
// Sequencer: takes a word, bound setup and scan for allocs, commits, presents.
// ----------------------------------------------------------------------------
module rbfa_ctrl import rbfa_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [1:0] in_type,
	input  logic       out_ready,
	input  rbfa_stat_t stat,
	output logic       in_ready,
	output logic       load,
	output rbfa_cmd_t  cmd,
	output logic       res_load,
	output logic       out_valid
);
	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_DIV  = 5'b00010,
		S_SCAN = 5'b00100,
		S_DEC  = 5'b01000,
		S_WAIT = 5'b10000
	} state_t;

	state_t state_q;
	logic   ovalid_q;
	logic   type_alloc_q;

	assign in_ready  = state_q == S_IDLE;
	assign load      = in_valid && in_ready;
	assign out_valid = ovalid_q;

	always_comb begin
		cmd = '0;
		res_load = 1'b0;
		case (state_q)
			S_WAIT: cmd.start_div = type_alloc_q;
			S_DIV:  if (stat.div_done) cmd.start_scan = 1'b1;
			S_DEC:  if (!ovalid_q || out_ready) begin
				cmd.commit = 1'b1;
				res_load   = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			ovalid_q     <= 1'b0;
			type_alloc_q <= 1'b0;
		end else begin
			ovalid_q <= res_load || (ovalid_q && !out_ready);
			case (state_q)
				S_IDLE: if (load) begin
					type_alloc_q <= in_type == REQ_ALLOC;
					state_q      <= (in_type == REQ_ALLOC) ? S_WAIT : S_DEC;
				end
				S_WAIT: state_q <= S_DIV;
				S_DIV:  if (stat.div_done) state_q <= S_SCAN;
				S_SCAN: if (stat.scan_done) state_q <= S_DEC;
				S_DEC:  if (!ovalid_q || out_ready) begin
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

### hdl/ranged_best_fit_buffer_allocator.sv
// ----------------------------------------------------------------------------
// ranged_best_fit_buffer_allocator
// Best-fit buffer reuse allocator over a table of MAX_ENTRIES entries.
// ----------------------------------------------------------------------------
// A buffer request word first has a bit-serial divider form the lower size
// bound, then scans every filled entry of the table once, one entry per
// cycle, and then commits and presents its result; release, preload and
// unused words go straight to their commit. The input takes no new word
// until the last one has committed. A result waits in an output register;
// while it is held, the following word stops before its commit and the
// input stays blocked.
module ranged_best_fit_buffer_allocator import rbfa_pkg::*; #(
	parameter int MAX_ENTRIES = 64,
	parameter int SIZE_BITS   = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [RANGE_W-1:0] cfg_wdata,
	input  logic               s_tvalid,
	output logic               s_tready,
	// req_size[31:0], device[39:32], data_type[43:40], node_color[51:44],
	// entry_id[57:52], zero fill
	input  logic [63:0]        s_tdata,
	// req_type
	input  logic [1:0]         s_tuser,
	output logic               m_tvalid,
	input  logic               m_tready,
	// granted_id[5:0], is_new[6], status[8:7], zero fill
	output logic [15:0]        m_tdata
);
	logic [RANGE_W-1:0] range_q;
	logic               load, res_load;
	rbfa_cmd_t          cmd;
	rbfa_stat_t         stat;
	logic [5:0]         gid;
	logic               fresh;
	logic [1:0]         st;
	logic [8:0]         res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) range_q <= RANGE_RESET;
		else if (cfg_we) range_q <= cfg_wdata;
	end

	rbfa_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(s_tvalid), .in_type(s_tuser),
		.out_ready(m_tready), .stat(stat), .in_ready(s_tready), .load(load),
		.cmd(cmd), .res_load(res_load), .out_valid(m_tvalid)
	);

	rbfa_datapath #(.MAX_ENTRIES(MAX_ENTRIES), .SIZE_BITS(SIZE_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .load(load), .req_type(s_tuser),
		.req_size(SIZE_BITS'(s_tdata[31:0])), .device(s_tdata[39:32]),
		.data_type(s_tdata[43:40]), .node_color(s_tdata[51:44]),
		.entry_id(s_tdata[57:52]), .match_range(range_q), .cmd(cmd),
		.stat(stat), .granted_id(gid), .is_new(fresh), .status(st)
	);

	always_ff @(posedge clk) begin
		if (res_load) res_q <= {st, fresh, gid};
	end

	assign m_tdata = {7'd0, res_q};

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped");
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result changed while waiting");
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("accepted word while busy");
endmodule

### tb/tb_ranged_best_fit_buffer_allocator.sv
// ----------------------------------------------------------------------------
// tb_ranged_best_fit_buffer_allocator
// Self-checking bench for the ranged best-fit buffer allocator.
// ----------------------------------------------------------------------------
// Words are driven on the input stream in bursts with gaps. A scoreboard keeps
// its own copy of the entry table and predicts each result; results are taken
// under a stalling receiver and compared field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_ranged_best_fit_buffer_allocator;
	import rbfa_pkg::*;

	localparam int NENT = 64;
	localparam int WD_LIMIT = 20000;
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	typedef struct packed {
		logic [1:0] status;
		logic       fresh;
		logic [5:0] gid;
	} grant_t;

	class alloc_scoreboard;
		bit          valid[NENT], free[NENT], fixed[NENT], wild[NENT];
		bit   [31:0] size[NENT];
		bit    [7:0] dev[NENT];
		bit    [3:0] dt[NENT];
		bit    [7:0] color[NENT];
		bit   [31:0] age[NENT];
		int          count;
		bit   [31:0] age_ctr;
		bit   [10:0] range;
		grant_t      pending[$];
		int          errors;
		int          checked;

		function new();
			range = RANGE_RESET;
		endfunction

		function bit usable(int i, bit [7:0] d, bit [3:0] t, bit [7:0] c);
			if (!valid[i] || !free[i] || dev[i] != d || dt[i] != t) return 0;
			return wild[i] || color[i] == c;
		endfunction

		function int append(bit [31:0] s, bit [7:0] d, bit [3:0] t, bit pre);
			int i;
			i = count;
			if (i >= NENT) return -1;
			valid[i] = 1; free[i] = pre; fixed[i] = pre; wild[i] = pre;
			size[i] = s; dev[i] = d; dt[i] = t; color[i] = 0; age[i] = 0;
			if (pre) begin
				age[i] = age_ctr;
				age_ctr++;
			end
			count = i + 1;
			return i;
		endfunction

		function int best_fit(bit [31:0] s, bit [7:0] d, bit [3:0] t, bit [7:0] c);
			bit [63:0] hi, lo;
			int b;
			b = -1;
			hi = 64'(s) * 64'(range);
			lo = 64'(s) / 64'(range);
			for (int i = 0; i < count; i++) begin
				if (!usable(i, d, t, c) || size[i] < s || 64'(size[i]) > hi) continue;
				if (b < 0 || size[i] < size[b] || (size[i] == size[b] && age[i] < age[b]))
					b = i;
			end
			if (b >= 0) return b;
			for (int i = 0; i < count; i++) begin
				if (!usable(i, d, t, c) || fixed[i]) continue;
				if (size[i] >= s || 64'(size[i]) < lo) continue;
				if (b < 0 || size[i] > size[b] || (size[i] == size[b] && age[i] > age[b]))
					b = i;
			end
			if (b >= 0) size[b] = s;
			return b;
		endfunction

		function void note_word(bit [1:0] kind, bit [63:0] w);
			grant_t g;
			bit [31:0] s;
			bit [5:0] id;
			int k;
			s = w[31:0];
			id = w[57:52];
			g = '0;
			if (kind == REQ_ALLOC || kind == REQ_PRELOAD) begin
				k = -1;
				if (kind == REQ_ALLOC && range != 0) begin
					k = best_fit(s, w[39:32], w[43:40], w[51:44]);
					if (k >= 0) free[k] = 0;
				end
				if (k < 0) begin
					k = append(s, w[39:32], w[43:40], kind == REQ_PRELOAD);
					if (k < 0) g.status = ST_FULL;
					else g.fresh = 1;
				end
				if (k >= 0) g.gid = k[5:0];
			end else if (kind == REQ_RELEASE) begin
				g.gid = id;
				if (id >= count || !valid[id]) begin
					g.status = ST_BAD_REL;
				end else begin
					free[id] = 1; wild[id] = 0; color[id] = w[51:44];
					age[id] = age_ctr;
					age_ctr++;
				end
			end
			pending = {pending, g};
		endfunction

		function void check_word(bit [15:0] w);
			grant_t e, a;
			a = w[8:0];
			checked++;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result %h", $time, w);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (e.gid != a.gid || e.fresh != a.fresh || e.status != a.status || w[15:9] != 0) begin
				$display("%0t: mismatch expected id=%0d new=%0d st=%0d, actual id=%0d new=%0d st=%0d",
					$time, e.gid, e.fresh, e.status, a.gid, a.fresh, a.status);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        cfg_we = 0;
	logic [10:0] cfg_wdata = '0;
	logic        s_tvalid = 0;
	logic        s_tready;
	logic [63:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 0;
	logic [15:0] m_tdata;

	alloc_scoreboard sb = new();
	int  idle_cycles = 0;
	int  sent = 0;
	bit  hold_off = 0;
	int  burst_left = 0;

	ranged_best_fit_buffer_allocator dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (m_tvalid && m_tready) sb.check_word(m_tdata);
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WD_LIMIT) begin
			$display("watchdog expired");
			$display("tb_ranged_best_fit_buffer_allocator: done, errors");
			$finish;
		end
	end

	// Receiver stall pattern: stretches of always ready, random stalls, or
	// a long hold-off when requested.
	initial begin
		int mode;
		forever begin
			mode = $urandom_range(0, 2);
			repeat ($urandom_range(10, 60)) begin
				@(negedge clk);
				if (hold_off) m_tready <= 0;
				else if (mode == 0) m_tready <= 1;
				else if (mode == 1) m_tready <= ($urandom_range(0, 3) != 0);
				else m_tready <= ($urandom_range(0, 3) == 0);
			end
		end
	end

	task automatic send(bit [1:0] kind, bit [31:0] s, bit [7:0] d, bit [3:0] t,
			bit [7:0] c, bit [5:0] id);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 8);
			if (gap > 0) begin
				s_tvalid <= 0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		s_tvalid <= 1;
		s_tuser <= kind;
		s_tdata <= {6'd0, id, c, t, d, s};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_word(kind, {6'd0, id, c, t, d, s});
		sent++;
		burst_left--;
		@(negedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (150) @(negedge clk);
	endtask

	task automatic set_range(bit [10:0] r);
		cfg_we <= 1;
		cfg_wdata <= r;
		@(negedge clk);
		cfg_we <= 0;
		sb.range = r;
	endtask

	// Random words biased toward reuse: small sizes, few devices, types
	// and colors, releases of live entries.
	task automatic random_word();
		int p;
		bit [31:0] s;
		p = $urandom_range(0, 99);
		s = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(1, 300);
		if (p < 45)
			send(REQ_ALLOC, s, $urandom_range(0, 1), $urandom_range(0, 1),
				$urandom_range(0, 2), $urandom);
		else if (p < 85)
			send(REQ_RELEASE, $urandom, $urandom_range(0, 1), $urandom_range(0, 1),
				$urandom_range(0, 2),
				(sb.count > 0 && p < 82) ? $urandom_range(0, sb.count - 1) : $urandom);
		else if (p < 92)
			send(REQ_PRELOAD, s, $urandom_range(0, 1), $urandom_range(0, 1),
				$urandom, $urandom);
		else if (p < 97)
			send(REQ_ALLOC, $urandom, $urandom, $urandom, $urandom, $urandom);
		else
			send(REQ_UNUSED, $urandom, $urandom, $urandom, $urandom, $urandom);
	endtask

	initial begin
		bit [10:0] ranges[6];
		repeat (6) @(negedge clk);
		arst_n <= 1;
		@(negedge clk);

		// Directed: extremes, every kind, reuse paths and invalid release.
		send(REQ_RELEASE, 0, 0, 0, 0, 6'd0);
		send(REQ_ALLOC, 32'hFFFF_FFFF, 8'hFF, 4'hF, 8'hFF, 6'h3F);
		send(REQ_ALLOC, 0, 0, 0, 0, 0);
		send(REQ_ALLOC, 100, 1, 2, 3, 0);
		send(REQ_RELEASE, 0, 0, 0, 8'hAA, 6'd2);
		send(REQ_ALLOC, 90, 1, 2, 8'hAA, 0);
		send(REQ_RELEASE, 0, 0, 0, 8'h55, 6'd2);
		send(REQ_RELEASE, 0, 0, 0, 8'h56, 6'd2);
		send(REQ_ALLOC, 400, 1, 2, 8'h56, 0);
		send(REQ_PRELOAD, 1000, 5, 6, 0, 0);
		send(REQ_ALLOC, 900, 5, 6, 8'h12, 0);
		send(REQ_RELEASE, 0, 0, 0, 7, 6'd4);
		send(REQ_ALLOC, 2000, 5, 6, 7, 0);
		send(REQ_UNUSED, 32'hFFFF_FFFF, 8'hFF, 4'hF, 8'hFF, 6'h3F);
		send(REQ_RELEASE, 0, 0, 0, 0, 6'h3F);
		send(REQ_RELEASE, 0, 0, 0, 1, 6'd1);
		send(REQ_ALLOC, 32'h8000_0000, 8'hFF, 4'hF, 1, 0);
		drain();

		ranges = '{11'd0, 11'd1, 11'd1024, 11'd2, 11'd16, 11'd4};
		foreach (ranges[r]) begin
			set_range(ranges[r]);
			repeat (230) random_word();
			if (r == 2) begin
				// Long receiver hold-off while the sender keeps offering words.
				fork
					begin
						hold_off = 1;
						repeat (400) @(negedge clk);
						hold_off = 0;
					end
					repeat (20) random_word();
				join
			end
			drain();
		end
		// Fill the table to the end to reach the full status.
		repeat (70) send(REQ_PRELOAD, $urandom_range(1, 9), 9, 9, 0, 0);
		send(REQ_ALLOC, 3, 9, 9, 0, 0);
		drain();

		$display("covered %0d words, %0d results, ranges 0..1024, full table", sent,
			sb.checked);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("tb_ranged_best_fit_buffer_allocator: done, clean");
		else
			$display("tb_ranged_best_fit_buffer_allocator: done, errors");
		$finish;
	end
endmodule
